// ===== hw/rtl/id_relabel_table_unit_macros.svh =====
// id_relabel_table_unit_macros.svh: assertion macros shared by the relabel table rtl
// expects signals named clk and rst_n in the module that uses them
`ifndef ID_RELABEL_TABLE_UNIT_MACROS_SVH
`define ID_RELABEL_TABLE_UNIT_MACROS_SVH

// condition holds on every clock edge out of reset
`define IDRT_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequence holds in the same cycle as the antecedent
`define IDRT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequence holds in the cycle after the antecedent
`define IDRT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/idrt_pkg.sv =====
// idrt_pkg: types and constants of the id relabel table
// no dependencies
`timescale 1ns / 1ps

package idrt_pkg;

  localparam int ID_W  = 16;        // global and local id width
  localparam int CNT_W = 17;        // item count width, holds the full id space
  localparam int LOG_W = ID_W + 1;  // presence bit plus local id

  // operation selector
  typedef enum logic [1:0] {
    FUNC_INSERT = 2'd0,
    FUNC_MAP    = 2'd1,
    FUNC_READ   = 2'd2,
    FUNC_RESET  = 2'd3
  } func_t;

  // controller states
  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_RD_A,
    S_CHK_A,
    S_CHK_B,
    S_RD_G,
    S_CHK_G,
    S_WALK,
    S_DONE
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic clear;     // one step of the power-up clearing pass
    logic accept;    // capture the input word
    logic chk_a;     // first lookup data is back, insert decision
    logic chk_b;     // second lookup data is back
    logic chk_g;     // reverse read data is back
    logic walk;      // one step of the table reset walk
    logic walk_end;  // walk done, drop the count
    logic load_out;  // move the result into the output register
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic  clear_last;  // clearing pass is at its last entry
    logic  walk_more;   // walk still has entries to read
    logic  walk_pend;   // walk read in flight
    logic  out_free;    // output register can take a word this cycle
    func_t func;        // operation of the word in work
  } stat_t;

endpackage

// ===== hw/rtl/idrt_in_if.sv =====
// idrt_in_if: input word channel of the relabel table
// depends on idrt_pkg for field widths
`timescale 1ns / 1ps

interface idrt_in_if;
  logic                      valid;
  logic                      ready;
  logic [1:0]                func;
  logic [idrt_pkg::ID_W-1:0] first_id;
  logic [idrt_pkg::ID_W-1:0] second_id;
  logic [idrt_pkg::ID_W-1:0] local_index;

  modport source (output valid, func, first_id, second_id, local_index, input ready);
  modport sink   (input valid, func, first_id, second_id, local_index, output ready);
endinterface

// ===== hw/rtl/idrt_out_if.sv =====
// idrt_out_if: result word channel of the relabel table
// depends on idrt_pkg for field widths
`timescale 1ns / 1ps

interface idrt_out_if;
  logic                       valid;
  logic                       ready;
  logic [idrt_pkg::ID_W-1:0]  first_local;
  logic [idrt_pkg::ID_W-1:0]  second_local;
  logic                       first_found;
  logic                       second_found;
  logic [idrt_pkg::ID_W-1:0]  global_id;
  logic                       was_new;
  logic [idrt_pkg::CNT_W-1:0] item_total;
  logic                       error;

  modport source (output valid, first_local, second_local, first_found, second_found,
                  global_id, was_new, item_total, error, input ready);
  modport sink   (input valid, first_local, second_local, first_found, second_found,
                  global_id, was_new, item_total, error, output ready);
endinterface

// ===== hw/rtl/idrt_ram.sv =====
// idrt_ram: generic single write, single read ram with registered read data
// no dependencies
`timescale 1ns / 1ps

module idrt_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== hw/rtl/idrt_ctrl.sv =====
// idrt_ctrl: sequencing state machine of the relabel table
// depends on idrt_pkg for state, command and status types
`timescale 1ns / 1ps

module idrt_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic [1:0]       in_func,
  output logic             in_ready,
  input  idrt_pkg::stat_t  stat,
  output idrt_pkg::cmd_t   cmd
);

  idrt_pkg::state_t state_r, state_nxt;
  idrt_pkg::func_t  in_op;

  assign in_op = idrt_pkg::func_t'(in_func);

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= idrt_pkg::S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      idrt_pkg::S_CLEAR: begin
        if (stat.clear_last) state_nxt = idrt_pkg::S_IDLE;
      end
      idrt_pkg::S_IDLE: begin
        if (in_valid) begin
          unique case (in_op)
            idrt_pkg::FUNC_INSERT: state_nxt = idrt_pkg::S_RD_A;
            idrt_pkg::FUNC_MAP:    state_nxt = idrt_pkg::S_RD_A;
            idrt_pkg::FUNC_READ:   state_nxt = idrt_pkg::S_RD_G;
            idrt_pkg::FUNC_RESET:  state_nxt = idrt_pkg::S_WALK;
          endcase
        end
      end
      idrt_pkg::S_RD_A: state_nxt = idrt_pkg::S_CHK_A;
      idrt_pkg::S_CHK_A: begin
        state_nxt = (stat.func == idrt_pkg::FUNC_MAP) ? idrt_pkg::S_CHK_B
                                                      : idrt_pkg::S_DONE;
      end
      idrt_pkg::S_CHK_B: state_nxt = idrt_pkg::S_DONE;
      idrt_pkg::S_RD_G:  state_nxt = idrt_pkg::S_CHK_G;
      idrt_pkg::S_CHK_G: state_nxt = idrt_pkg::S_DONE;
      idrt_pkg::S_WALK: begin
        if (!stat.walk_more && !stat.walk_pend) state_nxt = idrt_pkg::S_DONE;
      end
      idrt_pkg::S_DONE: begin
        if (stat.out_free) state_nxt = idrt_pkg::S_IDLE;
      end
      default: state_nxt = idrt_pkg::S_IDLE;
    endcase
  end

  // command outputs
  always_comb begin
    cmd          = '0;
    in_ready     = 1'b0;
    unique case (state_r)
      idrt_pkg::S_CLEAR: cmd.clear = 1'b1;
      idrt_pkg::S_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      idrt_pkg::S_RD_A:  ;
      idrt_pkg::S_CHK_A: cmd.chk_a = 1'b1;
      idrt_pkg::S_CHK_B: cmd.chk_b = 1'b1;
      idrt_pkg::S_RD_G:  ;
      idrt_pkg::S_CHK_G: cmd.chk_g = 1'b1;
      idrt_pkg::S_WALK: begin
        cmd.walk     = 1'b1;
        cmd.walk_end = !stat.walk_more && !stat.walk_pend;
      end
      idrt_pkg::S_DONE: cmd.load_out = stat.out_free;
      default: ;
    endcase
  end

endmodule

// ===== hw/rtl/idrt_datapath.sv =====
// idrt_datapath: id stores, item count, walk counter and output register
// depends on idrt_pkg, idrt_ram and the assertion macro header
`timescale 1ns / 1ps
`include "id_relabel_table_unit_macros.svh"

module idrt_datapath #(
  parameter int unsigned CAPACITY = 65536
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  idrt_pkg::cmd_t             cmd,
  output idrt_pkg::stat_t            stat,
  input  logic [1:0]                 in_func,
  input  logic [idrt_pkg::ID_W-1:0]  in_first_id,
  input  logic [idrt_pkg::ID_W-1:0]  in_second_id,
  input  logic [idrt_pkg::ID_W-1:0]  in_local_index,
  input  logic                       out_ready,
  output logic                       out_valid,
  output logic [idrt_pkg::ID_W-1:0]  out_first_local,
  output logic [idrt_pkg::ID_W-1:0]  out_second_local,
  output logic                       out_first_found,
  output logic                       out_second_found,
  output logic [idrt_pkg::ID_W-1:0]  out_global_id,
  output logic                       out_was_new,
  output logic [idrt_pkg::CNT_W-1:0] out_item_total,
  output logic                       out_error
);

  // ids are 16 bits wide, so no store needs more entries than the id space
  localparam int unsigned ID_SPACE = 1 << idrt_pkg::ID_W;
  localparam int unsigned DEPTH    = (CAPACITY < ID_SPACE) ? CAPACITY : ID_SPACE;
  localparam int          AW       = $clog2(DEPTH);
  localparam int          CW       = idrt_pkg::CNT_W;
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

  // captured word
  idrt_pkg::func_t           func_r;
  logic [idrt_pkg::ID_W-1:0] a_r, b_r, idx_r;

  // control registers
  logic [CW-1:0] count_r, count_nxt;
  logic [AW:0]   sweep_r, sweep_nxt;
  logic          pend_r, pend_nxt;
  logic          out_valid_r, out_valid_nxt;

  // working result
  logic [idrt_pkg::ID_W-1:0] la_r, la_nxt, lb_r, lb_nxt, gid_r, gid_nxt;
  logic                      fa_r, fa_nxt, fb_r, fb_nxt, new_r, new_nxt, err_r, err_nxt;

  // output register
  logic [idrt_pkg::ID_W-1:0] o_la_r, o_lb_r, o_gid_r;
  logic                      o_fa_r, o_fb_r, o_new_r, o_err_r;
  logic [CW-1:0]             o_total_r;

  // ram ports
  logic                       log_we, gol_we;
  logic [AW-1:0]              log_waddr, log_raddr, gol_raddr;
  logic [idrt_pkg::LOG_W-1:0] log_wdata, log_rdata;
  logic [idrt_pkg::ID_W-1:0]  gol_rdata;

  // lookup decode
  logic a_in, b_in, hit_a, hit_b, g_in, ins_ok;
  logic [idrt_pkg::ID_W-1:0] walk_g;

  assign a_in   = {1'b0, a_r} < DEPTH_C;
  assign b_in   = {1'b0, b_r} < DEPTH_C;
  assign hit_a  = a_in && log_rdata[idrt_pkg::ID_W];
  assign hit_b  = b_in && log_rdata[idrt_pkg::ID_W];
  assign walk_g = gol_rdata;
  assign g_in   = {1'b0, walk_g} < DEPTH_C;
  assign ins_ok = cmd.chk_a && (func_r == idrt_pkg::FUNC_INSERT) && !hit_a && a_in &&
                  (count_r < DEPTH_C);

  // status to controller
  assign stat.clear_last = sweep_r[AW-1:0] == AW'(DEPTH - 1);
  assign stat.walk_more  = CW'(sweep_r) < count_r;
  assign stat.walk_pend  = pend_r;
  assign stat.out_free   = !out_valid_r || out_ready;
  assign stat.func       = func_r;

  // read addresses: second id is looked up while the first one is checked
  assign log_raddr = cmd.chk_a ? b_r[AW-1:0] : a_r[AW-1:0];
  assign gol_raddr = cmd.walk ? sweep_r[AW-1:0] : idx_r[AW-1:0];

  // id to local store writes: clearing pass, insert, walk
  always_comb begin
    log_we    = 1'b0;
    log_waddr = a_r[AW-1:0];
    log_wdata = '0;
    priority if (cmd.clear) begin
      log_we    = 1'b1;
      log_waddr = sweep_r[AW-1:0];
    end else if (ins_ok) begin
      log_we    = 1'b1;
      log_wdata = {1'b1, count_r[idrt_pkg::ID_W-1:0]};
    end else if (cmd.walk && pend_r && g_in) begin
      log_we    = 1'b1;
      log_waddr = walk_g[AW-1:0];
    end
  end

  assign gol_we = ins_ok;

  // next values of counters and working result
  always_comb begin
    count_nxt     = count_r;
    sweep_nxt     = sweep_r;
    pend_nxt      = pend_r;
    la_nxt        = la_r;
    lb_nxt        = lb_r;
    gid_nxt       = gid_r;
    fa_nxt        = fa_r;
    fb_nxt        = fb_r;
    new_nxt       = new_r;
    err_nxt       = err_r;
    out_valid_nxt = out_valid_r;
    if (out_ready) out_valid_nxt = 1'b0;
    if (cmd.load_out) out_valid_nxt = 1'b1;

    if (cmd.clear) sweep_nxt = sweep_r + 1'b1;

    if (cmd.accept) begin
      la_nxt    = '0;
      lb_nxt    = '0;
      gid_nxt   = '0;
      fa_nxt    = 1'b0;
      fb_nxt    = 1'b0;
      new_nxt   = 1'b0;
      err_nxt   = 1'b0;
      sweep_nxt = '0;
      pend_nxt  = 1'b0;
    end

    // first lookup, and the insert that may follow it
    if (cmd.chk_a) begin
      fa_nxt = hit_a;
      la_nxt = hit_a ? log_rdata[idrt_pkg::ID_W-1:0] : '0;
      if (ins_ok) begin
        la_nxt    = count_r[idrt_pkg::ID_W-1:0];
        new_nxt   = 1'b1;
        count_nxt = count_r + 1'b1;
      end
    end

    if (cmd.chk_b) begin
      fb_nxt = hit_b;
      lb_nxt = hit_b ? log_rdata[idrt_pkg::ID_W-1:0] : '0;
    end

    // reverse read, index checked against the count
    if (cmd.chk_g) begin
      err_nxt = !({1'b0, idx_r} < count_r);
      gid_nxt = ({1'b0, idx_r} < count_r) ? gol_rdata : '0;
    end

    // walk: read one local entry a cycle, clear the mark it points at next cycle
    if (cmd.walk) begin
      pend_nxt = stat.walk_more;
      if (stat.walk_more) sweep_nxt = sweep_r + 1'b1;
    end
    if (cmd.walk_end) count_nxt = '0;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      sweep_r     <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      sweep_r     <= sweep_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      func_r <= idrt_pkg::func_t'(in_func);
      a_r    <= in_first_id;
      b_r    <= in_second_id;
      idx_r  <= in_local_index;
    end
    la_r  <= la_nxt;
    lb_r  <= lb_nxt;
    gid_r <= gid_nxt;
    fa_r  <= fa_nxt;
    fb_r  <= fb_nxt;
    new_r <= new_nxt;
    err_r <= err_nxt;
    if (cmd.load_out) begin
      o_la_r    <= la_r;
      o_lb_r    <= lb_r;
      o_gid_r   <= gid_r;
      o_fa_r    <= fa_r;
      o_fb_r    <= fb_r;
      o_new_r   <= new_r;
      o_err_r   <= err_r;
      o_total_r <= count_r;
    end
  end

  // presence bit and local id, indexed by global id
  idrt_ram #(
    .WIDTH (idrt_pkg::LOG_W),
    .DEPTH (DEPTH)
  ) u_log_ram (
    .clk   (clk),
    .we    (log_we),
    .waddr (log_waddr),
    .wdata (log_wdata),
    .raddr (log_raddr),
    .rdata (log_rdata)
  );

  // global id, indexed by local id
  idrt_ram #(
    .WIDTH (idrt_pkg::ID_W),
    .DEPTH (DEPTH)
  ) u_gol_ram (
    .clk   (clk),
    .we    (gol_we),
    .waddr (count_r[AW-1:0]),
    .wdata (a_r),
    .raddr (gol_raddr),
    .rdata (gol_rdata)
  );

  assign out_valid        = out_valid_r;
  assign out_first_local  = o_la_r;
  assign out_second_local = o_lb_r;
  assign out_first_found  = o_fa_r;
  assign out_second_found = o_fb_r;
  assign out_global_id    = o_gid_r;
  assign out_was_new      = o_new_r;
  assign out_item_total   = o_total_r;
  assign out_error        = o_err_r;

  // checks
  `IDRT_ASSERT_ALWAYS(a_count_bound, count_r <= DEPTH_C, "item count above table depth")
  `IDRT_ASSERT_NXT(a_load_shows, cmd.load_out, out_valid_r, "loaded word not offered")
  `IDRT_ASSERT_NXT(a_insert_counts, ins_ok, count_r == $past(count_r) + CW'(1), "insert lost count")

endmodule

// ===== hw/rtl/id_relabel_table_unit.sv =====
// id_relabel_table_unit: top level of the direct mapped id compaction table
// depends on idrt_pkg, idrt_in_if, idrt_out_if, idrt_ctrl and idrt_datapath
`timescale 1ns / 1ps

// Relabels sparse 16-bit global ids to dense local ids in first-seen order.
// One input word carries one operation (insert, edge map, reverse read, table
// reset) and gives one result word. After reset the block first clears the
// presence store, one entry a cycle, over min(CAPACITY, 65536) entries, and
// takes no word until that pass is done. The id store has one read port with
// registered read data, so insert and reverse read each issue one read and
// then check its data, and edge map checks the first lookup and then the
// second (the two lookups share that port). Table reset walks one inserted
// entry per cycle, then clears the mark of the last one and ends the walk. The
// output register lets a new word be taken while the previous result waits.

module id_relabel_table_unit #(
  parameter int unsigned CAPACITY = 65536
) (
  input logic        clk,
  input logic        rst_n,
  idrt_in_if.sink    in_word,
  idrt_out_if.source out_word
);

  idrt_pkg::cmd_t  cmd;
  idrt_pkg::stat_t stat;

  // sequencer
  idrt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_word.valid),
    .in_func  (in_word.func),
    .in_ready (in_word.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // stores and result path
  idrt_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .in_func          (in_word.func),
    .in_first_id      (in_word.first_id),
    .in_second_id     (in_word.second_id),
    .in_local_index   (in_word.local_index),
    .out_ready        (out_word.ready),
    .out_valid        (out_word.valid),
    .out_first_local  (out_word.first_local),
    .out_second_local (out_word.second_local),
    .out_first_found  (out_word.first_found),
    .out_second_found (out_word.second_found),
    .out_global_id    (out_word.global_id),
    .out_was_new      (out_word.was_new),
    .out_item_total   (out_word.item_total),
    .out_error        (out_word.error)
  );

endmodule
